// ===== sv/bgr_pkg.sv =====
package bgr_pkg;

  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_ROWS  = 16;
  localparam int FIRST_CODE  = 32'h20;
  localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GIDX_W      = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int ROW_W       = 4;
  localparam int STRIDE_W    = 13;
  localparam int PIX_W       = 23;
  localparam int COLOR_W     = 24;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd480;
  localparam logic [ROW_W-1:0]    LAST_ROW     = ROW_W'(GLYPH_ROWS - 1);
  localparam logic [7:0]          ALL_PIXELS   = 8'hFF;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROWS,
    ST_BAD
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         char_code;
    logic [3:0]         font_row;
    logic [7:0]         font_bits;
    logic [9:0]         pos_x;
    logic [9:0]         pos_y;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               fill_background;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_address;
    logic [7:0]         fg_mask;
    logic [7:0]         write_mask;
    logic [COLOR_W-1:0] out_fg_color;
    logic [COLOR_W-1:0] out_bg_color;
    logic [ROW_W-1:0]   row_number;
    logic               last_row;
    logic               bad_code;
  } out_item_t;

  // Row metadata travelling alongside the font memory read
  typedef struct packed {
    logic [PIX_W-1:0]   addr;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [ROW_W-1:0]   row;
    logic               last;
    logic               bad;
    logic               fill;
  } row_meta_t;

  function automatic logic code_ok(input logic [7:0] code);
    logic [8:0] rel;
    rel = {1'b0, code} - 9'(FIRST_CODE);
    return (32'(code) >= FIRST_CODE) && (32'(rel) < GLYPH_COUNT);
  endfunction

  function automatic logic [GIDX_W-1:0] glyph_of(input logic [7:0] code);
    logic [7:0] rel;
    rel = code - 8'(FIRST_CODE);
    return GIDX_W'(rel);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [GIDX_W-1:0] g,
                                                   input logic [ROW_W-1:0] r);
    return ADDR_W'(32'(g) * GLYPH_ROWS + 32'(r));
  endfunction

endpackage

// ===== sv/bitmap_glyph_row_renderer_unit.sv =====
// Bitmap glyph row renderer: turns character draw transactions into frame
// buffer row writes from a loaded 8x16 font (96 glyphs, codes 0x20..0x7F).
//
// Input channel in_valid/in_stall/in_data: cmd 0 writes one font row into
// the on-chip font memory and produces nothing; cmd 1 draws a character and
// produces 16 output transactions, one per glyph row, last_row on the final
// one. A code without a glyph produces a single transaction with bad_code.
// Output channel out_valid/out_stall/out_data; output is fully registered.
// cfg_write/cfg_data set line_stride; write it only while the block is idle.
//
// Sequencing: a load is accepted without holding the input. A draw holds the
// input through ST_SETUP (the start address product), then through ST_ROWS,
// one row a cycle while the output does not stall, paced by the single font
// memory read port; each row then passes the read stage and the output
// register. A bad code holds the input through ST_BAD.
// The row address comes from one accumulator: start = x + stride*y, then
// stride is added once per row.
// Reset: line_stride returns to 480, control clears; font memory contents
// are undefined until loaded (no clearing pass).
// A stalled output freezes the whole row pipeline; nothing is dropped.
module bitmap_glyph_row_renderer_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  bgr_pkg::in_item_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output bgr_pkg::out_item_t      out_data,
  input  logic                    cfg_write,
  input  logic [12:0]             cfg_data
);
  import bgr_pkg::*;

  logic [7:0] font_mem [STORE_DEPTH];

  state_t state, state_next;

  logic [STRIDE_W-1:0] line_stride;

  // item registers (payload, no reset)
  logic [GIDX_W-1:0]  glyph;
  logic [9:0]         px, py;
  logic [COLOR_W-1:0] fg, bg;
  logic               fill;

  logic [PIX_W-1:0] acc;
  logic [ROW_W-1:0] row_cnt;

  // read stage
  logic       b_vld;
  row_meta_t  b_meta, b_meta_next;
  logic [7:0] mem_q;

  logic in_acc, adv, issue, load_ok;
  logic [7:0] row_bits;

  assign in_acc  = in_valid && !in_stall;
  assign adv     = !out_valid || !out_stall;
  assign load_ok = code_ok(in_data.char_code) && (32'(in_data.font_row) < GLYPH_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && in_data.cmd == CMD_DRAW) begin
          state_next = code_ok(in_data.char_code) ? ST_SETUP : ST_BAD;
        end
      end
      ST_SETUP: begin
        state_next = ST_ROWS;
      end
      ST_ROWS: begin
        if (adv) begin
          issue = 1'b1;
          if (row_cnt == LAST_ROW) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_BAD: begin
        if (adv) begin
          issue      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_stride <= STRIDE_RESET;
    end else if (cfg_write) begin
      line_stride <= cfg_data;
    end
  end

  // capture the draw request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      glyph <= glyph_of(in_data.char_code);
      px    <= in_data.pos_x;
      py    <= in_data.pos_y;
      fg    <= in_data.fg_color;
      bg    <= in_data.bg_color;
      fill  <= in_data.fill_background;
    end
  end

  // shared address unit: start product, then one stride add per row
  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      acc     <= PIX_W'(32'(px) + 32'(line_stride) * 32'(py));
      row_cnt <= '0;
    end else if (state == ST_ROWS && issue) begin
      acc     <= acc + PIX_W'(line_stride);
      row_cnt <= row_cnt + 1'b1;
    end
  end

  // font memory: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_data.cmd == CMD_LOAD && load_ok) begin
      font_mem[store_addr(glyph_of(in_data.char_code), in_data.font_row)] <=
        in_data.font_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && state == ST_ROWS) begin
      mem_q <= font_mem[store_addr(glyph, row_cnt)];
    end
  end

  always_comb begin
    b_meta_next = '0;
    if (state == ST_BAD) begin
      b_meta_next.last = 1'b1;
      b_meta_next.bad  = 1'b1;
    end else begin
      b_meta_next.addr = acc;
      b_meta_next.fg   = fg;
      b_meta_next.bg   = bg;
      b_meta_next.row  = row_cnt;
      b_meta_next.last = (row_cnt == LAST_ROW);
      b_meta_next.fill = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue) begin
      b_meta <= b_meta_next;
    end
  end

  assign row_bits = b_meta.bad ? 8'h00 : mem_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_vld) begin
      out_data.pixel_address <= b_meta.addr;
      out_data.fg_mask       <= row_bits;
      out_data.write_mask    <= (b_meta.fill && !b_meta.bad) ? ALL_PIXELS : row_bits;
      out_data.out_fg_color  <= b_meta.fg;
      out_data.out_bg_color  <= b_meta.bg;
      out_data.row_number    <= b_meta.row;
      out_data.last_row      <= b_meta.last;
      out_data.bad_code      <= b_meta.bad;
    end
  end

  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_code |->
      out_data.fg_mask == 8'h00 && out_data.write_mask == 8'h00 && out_data.last_row)
    else $error("bad-code transaction malformed");

  a_fg_in_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.fg_mask & ~out_data.write_mask) == 8'h00)
    else $error("foreground pixel outside write mask");

  a_setup_to_rows: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP |=> state == ST_ROWS && row_cnt == '0)
    else $error("row sequence did not start at row zero");

  a_last_issue_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROWS && issue && row_cnt == LAST_ROW |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after last row");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    b_vld && !adv |=> b_vld && $stable(b_meta))
    else $error("read stage changed while output stalled");

endmodule

// ===== bench/bitmap_glyph_row_renderer_unit_tb.sv =====
module bitmap_glyph_row_renderer_unit_tb;

  import bgr_pkg::*;

  // Generous ceiling: ~200 input transactions, up to 16 rows each, every row
  // possibly waiting out the longest output stall run, plus sender gaps.
  localparam int LIMIT_CYCLES = 400000;
  // Tail wait after the last expected row.
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_write = 1'b0;
  logic [STRIDE_W-1:0] cfg_data = '0;

  bitmap_glyph_row_renderer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the block: font memory and line stride, updated as
  // transactions are accepted, feeding the queue of expected row writes.
  // ---------------------------------------------------------------------
  logic [7:0]          font_copy [STORE_DEPTH];
  logic [STRIDE_W-1:0] stride_copy = STRIDE_RESET;
  out_item_t           expected_rows [$];

  // Stimulus side: transactions waiting for the driver, plus the generator's
  // own view of which glyphs are fully loaded (draws only touch those).
  in_item_t pending_items [$];
  bit       glyph_ready [GLYPH_COUNT];
  int       ready_codes [$];

  int pushed_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int loads_seen = 0;
  int draws_seen = 0;
  int bad_seen = 0;
  int rows_checked = 0;
  int stride_settings = 0;

  // Expected rows for one accepted transaction. Loads update the font copy
  // only; codes without a glyph yield a single flagged, all-zero row.
  task automatic predict_rows(input in_item_t it);
    out_item_t  row;
    logic [31:0] addr;
    int          slot;
    bit          has_glyph;
    has_glyph = (it.char_code >= FIRST_CODE) && (it.char_code < FIRST_CODE + GLYPH_COUNT);
    if (it.cmd == CMD_LOAD) begin
      if (has_glyph && it.font_row < GLYPH_ROWS) begin
        slot = (int'(it.char_code) - FIRST_CODE) * GLYPH_ROWS + int'(it.font_row);
        font_copy[slot] = it.font_bits;
      end
    end else if (!has_glyph) begin
      row = '0;
      row.last_row = 1'b1;
      row.bad_code = 1'b1;
      expected_rows.push_back(row);
    end else begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        slot = (int'(it.char_code) - FIRST_CODE) * GLYPH_ROWS + r;
        // Address wraps at the 23-bit pixel address width
        addr = 32'(it.pos_x) + 32'(stride_copy) * (32'(it.pos_y) + 32'(r));
        row.pixel_address = PIX_W'(addr);
        row.fg_mask       = font_copy[slot];
        row.write_mask    = it.fill_background ? ALL_PIXELS : font_copy[slot];
        row.out_fg_color  = it.fg_color;
        row.out_bg_color  = it.bg_color;
        row.row_number    = ROW_W'(r);
        row.last_row      = (r == GLYPH_ROWS - 1);
        row.bad_code      = 1'b0;
        expected_rows.push_back(row);
      end
    end
  endtask

  task automatic check_row(input out_item_t got, input out_item_t want);
    if (got.pixel_address !== want.pixel_address) begin
      $error("pixel_address: expected %0h, actual %0h", want.pixel_address, got.pixel_address);
      error_count++;
    end
    if (got.fg_mask !== want.fg_mask) begin
      $error("fg_mask: expected %0h, actual %0h", want.fg_mask, got.fg_mask);
      error_count++;
    end
    if (got.write_mask !== want.write_mask) begin
      $error("write_mask: expected %0h, actual %0h", want.write_mask, got.write_mask);
      error_count++;
    end
    if (got.out_fg_color !== want.out_fg_color) begin
      $error("out_fg_color: expected %0h, actual %0h", want.out_fg_color, got.out_fg_color);
      error_count++;
    end
    if (got.out_bg_color !== want.out_bg_color) begin
      $error("out_bg_color: expected %0h, actual %0h", want.out_bg_color, got.out_bg_color);
      error_count++;
    end
    if (got.row_number !== want.row_number) begin
      $error("row_number: expected %0d, actual %0d", want.row_number, got.row_number);
      error_count++;
    end
    if (got.last_row !== want.last_row) begin
      $error("last_row: expected %0b, actual %0b", want.last_row, got.last_row);
      error_count++;
    end
    if (got.bad_code !== want.bad_code) begin
      $error("bad_code: expected %0b, actual %0b", want.bad_code, got.bad_code);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers. Every field starts fully random so unused fields
  // still toggle; callers then pin the ones that matter.
  // ---------------------------------------------------------------------
  function automatic in_item_t rand_item();
    in_item_t it;
    it.cmd             = 1'($urandom);
    it.char_code       = 8'($urandom);
    it.font_row        = 4'($urandom);
    it.font_bits       = 8'($urandom);
    it.pos_x           = 10'($urandom);
    it.pos_y           = 10'($urandom);
    it.fg_color        = 24'($urandom);
    it.bg_color        = 24'($urandom);
    it.fill_background = 1'($urandom);
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    pending_items.push_back(it);
    pushed_count++;
  endtask

  task automatic push_load(input int code, input int row, input logic [7:0] bits);
    in_item_t it;
    it = rand_item();
    it.cmd       = CMD_LOAD;
    it.char_code = 8'(code);
    it.font_row  = 4'(row);
    it.font_bits = bits;
    push_item(it);
  endtask

  task automatic push_draw(input int code, input bit edge_pos);
    in_item_t it;
    it = rand_item();
    it.cmd       = CMD_DRAW;
    it.char_code = 8'(code);
    if (edge_pos) begin
      it.pos_x = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      it.pos_y = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    end
    push_item(it);
  endtask

  // Whole glyph in a rotated row order; rows occasionally blank or solid.
  task automatic load_glyph(input int code);
    int          start;
    int          pick;
    logic [7:0]  bits;
    start = $urandom_range(0, GLYPH_ROWS - 1);
    for (int i = 0; i < GLYPH_ROWS; i++) begin
      pick = $urandom_range(0, 9);
      bits = (pick == 0) ? 8'h00 : (pick == 1) ? ALL_PIXELS : 8'($urandom);
      push_load(code, (start + i) % GLYPH_ROWS, bits);
    end
    if (!glyph_ready[code - FIRST_CODE]) begin
      glyph_ready[code - FIRST_CODE] = 1'b1;
      ready_codes.push_back(code);
    end
  endtask

  function automatic int bad_code_value();
    return $urandom_range(0, 1) ? $urandom_range(0, FIRST_CODE - 1)
                                : $urandom_range(FIRST_CODE + GLYPH_COUNT, 255);
  endfunction

  task automatic queue_directed();
    logic [7:0] patterns [GLYPH_ROWS];
    in_item_t   it;
    patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                 8'h18, 8'h81, 8'h7E, 8'hC3, 8'h3C, 8'h24, 8'h42, 8'h99};
    for (int r = 0; r < GLYPH_ROWS; r++)
      push_load(FIRST_CODE, r, patterns[r]);
    glyph_ready[0] = 1'b1;
    ready_codes.push_back(FIRST_CODE);
    // Loads to codes without a glyph must leave the font untouched
    push_load(FIRST_CODE - 1, 0, 8'hFF);
    push_load(FIRST_CODE + GLYPH_COUNT, 5, 8'hFF);
    // Origin, no background fill, black on black
    it = rand_item();
    it.cmd = CMD_DRAW; it.char_code = 8'(FIRST_CODE);
    it.pos_x = '0; it.pos_y = '0; it.fg_color = '0; it.bg_color = '0;
    it.fill_background = 1'b0;
    push_item(it);
    // Far corner, background fill, all-ones colours
    it.pos_x = '1; it.pos_y = '1; it.fg_color = '1; it.bg_color = '1;
    it.fill_background = 1'b1;
    push_item(it);
    // Boundaries of the glyph range on either side
    push_draw(8'h00, 1'b0);
    push_draw(FIRST_CODE - 1, 1'b0);
    push_draw(FIRST_CODE + GLYPH_COUNT, 1'b0);
    push_draw(8'hFF, 1'b0);
  endtask

  // Mostly draws of loaded glyphs; some glyph loads, row rewrites, code
  // misses and ignored loads mixed in.
  task automatic queue_phase(input int budget);
    int used;
    int sel;
    int code;
    used = 0;
    while (used < budget) begin
      sel = $urandom_range(0, 99);
      if (ready_codes.size() < 2 || sel < 8) begin
        code = !glyph_ready[GLYPH_COUNT - 1] ? FIRST_CODE + GLYPH_COUNT - 1
                                             : $urandom_range(FIRST_CODE,
                                                              FIRST_CODE + GLYPH_COUNT - 1);
        load_glyph(code);
        used += GLYPH_ROWS;
      end else if (sel < 22) begin
        code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
        push_load(code, $urandom_range(0, GLYPH_ROWS - 1), 8'($urandom));
        used++;
      end else if (sel < 27) begin
        // ignored by the block, not counted
        push_load(bad_code_value(), $urandom_range(0, GLYPH_ROWS - 1), 8'($urandom));
      end else if (sel < 37) begin
        push_draw(bad_code_value(), $urandom_range(0, 4) == 0);
        used++;
      end else begin
        code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
        push_draw(code, $urandom_range(0, 4) == 0);
        used++;
      end
    end
  endtask

  // Sender holds off until every queued transaction is in and every row
  // write has come back, then lets the pipeline settle.
  task automatic drain();
    while (accepted_count != pushed_count || expected_rows.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stride(input logic [STRIDE_W-1:0] value);
    @(posedge clk);
    cfg_data  <= value;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write   <= 1'b0;
    stride_copy = value;
    stride_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Input driver: bursts of random length separated by random gaps; gap
  // zero now and then gives back-to-back stretches. Payload holds while
  // stalled, predictions are made at the accepting edge.
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin : drive_in
    logic launch;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rows(in_data);
        accepted_count++;
        if (in_data.cmd == CMD_LOAD)
          loads_seen++;
        else if (in_data.char_code < FIRST_CODE ||
                 in_data.char_code >= FIRST_CODE + GLYPH_COUNT)
          bad_seen++;
        else
          draws_seen++;
      end
      if (!in_valid || !in_stall) begin
        launch = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          launch = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= launch;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor and stall pattern. Modes are picked at random: never stall,
  // random stall, periodic stall, and occasional long stall runs.
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left = 0;
  int stall_run = 0;

  always @(posedge clk) begin : watch_out
    out_item_t want;
    logic      stall_next;
    if (!rst && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected output transaction: %h", out_data);
        error_count++;
      end else begin
        want = expected_rows.pop_front();
        check_row(out_data, want);
        rows_checked++;
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: stall_next = 1'b0;
      1: stall_next = ($urandom_range(0, 99) < 35);
      2: stall_next = (mode_left % 3 == 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          stall_next = 1'b1;
        end else begin
          stall_next = 1'b0;
          if ($urandom_range(0, 9) == 0)
            stall_run = $urandom_range(2, 10);
        end
      end
    endcase
    out_stall <= stall_next;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d rows still expected",
               cycle_count, expected_rows.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed set at the reset stride, then one random
  // phase per stride setting (extremes, zero, wrap-around, the reset value, random).
  // ---------------------------------------------------------------------
  initial begin : run_seq
    logic [STRIDE_W-1:0] strides [7];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    drain();
    strides = '{13'd1, 13'd4096, 13'h1FFF, 13'd0, STRIDE_RESET,
                13'($urandom_range(1, 4096)), 13'($urandom)};
    foreach (strides[i]) begin
      write_stride(strides[i]);
      queue_phase(PHASE_ITEMS);
      drain();
    end
    if (expected_rows.size() != 0) begin
      $error("%0d expected rows never arrived", expected_rows.size());
      error_count++;
    end
    $display("covered %0d loads, %0d glyph draws, %0d code misses under %0d stride settings",
             loads_seen, draws_seen, bad_seen, stride_settings + 1);
    $display("%0d row writes compared, %0d mismatches", rows_checked, error_count);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bgr_pkg.sv
sv/bitmap_glyph_row_renderer_unit.sv
bench/bitmap_glyph_row_renderer_unit_tb.sv
